/* design/wasc_pkg.sv */
// Shared types and constants of the weekly alarm scheduler.
// Used by the front end, the back end and the top level; depends on nothing.
package wasc_pkg;

  localparam int CAPACITY        = 16;
  localparam int IDX_W           = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W           = $clog2(CAPACITY + 1);
  localparam int QUEUE_DEPTH     = 2;

  localparam int SECONDS_PER_DAY = 24 * 3600;
  localparam int DAYS_PER_WEEK   = 7;

  localparam int OPC_W      = 3;
  localparam int TIME_W     = 17;
  localparam int WDAY_W     = 3;
  localparam int MASK_W     = 7;
  localparam int INDEX_IN_W = 8;
  localparam int ACT_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int INDEX_OUT_W = 4;
  localparam int DELTA_W    = 20;
  localparam int DAYS_W     = 3;
  localparam int SUM_W      = DELTA_W + 1;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 88;

  localparam logic [OPC_W-1:0] OP_INSERT    = 3'd0;
  localparam logic [OPC_W-1:0] OP_REMOVE    = 3'd1;
  localparam logic [OPC_W-1:0] OP_RECOMPUTE = 3'd2;
  localparam logic [OPC_W-1:0] OP_TRIGGER   = 3'd3;
  localparam logic [OPC_W-1:0] OP_INSPECT   = 3'd4;

  typedef enum logic [2:0] {
    CMD_INSERT,
    CMD_REMOVE,
    CMD_RECOMPUTE,
    CMD_TRIGGER,
    CMD_INSPECT,
    CMD_NOP
  } cmd_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_NO_SEL    = 2'd3
  } status_t;

  // Classified command as it waits between front and back end.
  typedef struct packed {
    cmd_kind_t          kind;
    logic [TIME_W-1:0]  now_sec;
    logic [WDAY_W-1:0]  wday;      // normalized to 0..6
    logic               wday_ok;   // weekday was a real day
    logic [TIME_W-1:0]  new_time;
    logic [MASK_W-1:0]  new_mask;
    logic [IDX_W-1:0]   idx;
    logic               idx_in_range;
    logic [ACT_W-1:0]   new_action;
  } cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0] alarm_time;
    logic [MASK_W-1:0] day_mask;
    logic [ACT_W-1:0]  action;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    status_t                status;
    logic                   next_found;
    logic [INDEX_OUT_W-1:0] next_index;
    logic [DELTA_W-1:0]     next_delta;
    logic                   fire;
    logic [TIME_W-1:0]      read_time;
    logic [MASK_W-1:0]      read_mask;
    logic [ACT_W-1:0]       read_action;
  } res_t;

  function automatic logic [DELTA_W-1:0] day_seconds(input logic [DAYS_W-1:0] days);
    return DELTA_W'(int'(days) * SECONDS_PER_DAY);
  endfunction

endpackage

/* design/wasc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Self-contained; holds the alarm table of the scheduler.
module wasc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

/* design/wasc_front.sv */
// Front end: accepts input items, classifies them and queues the commands.
// Depends on wasc_pkg.
module wasc_front import wasc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // now_seconds, now_weekday, new_alarm_time, new_day_mask, entry_index, new_action
  input  logic [IN_DATA_W-1:0] in_tdata,
  // opcode
  input  logic [OPC_W-1:0]     in_tuser,
  output logic                 q_valid,
  output cmd_t                 q_cmd,
  input  logic                 q_pop
);

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] fill_r;
  cmd_t              cls;
  logic              push;

  logic [WDAY_W-1:0]     f_wday;
  logic [INDEX_IN_W-1:0] f_index;

  assign f_wday  = in_tdata[19:17];
  assign f_index = in_tdata[51:44];

  always_comb begin
    unique case (in_tuser)
      OP_INSERT:    cls.kind = CMD_INSERT;
      OP_REMOVE:    cls.kind = CMD_REMOVE;
      OP_RECOMPUTE: cls.kind = CMD_RECOMPUTE;
      OP_TRIGGER:   cls.kind = CMD_TRIGGER;
      OP_INSPECT:   cls.kind = CMD_INSPECT;
      default:      cls.kind = CMD_NOP;
    endcase
    cls.now_sec      = in_tdata[16:0];
    // weekday 7 matches no mask bit and walks from Sunday
    cls.wday_ok      = (f_wday < WDAY_W'(DAYS_PER_WEEK));
    cls.wday         = cls.wday_ok ? f_wday : '0;
    cls.new_time     = in_tdata[36:20];
    cls.new_mask     = in_tdata[43:37];
    cls.idx_in_range = (f_index < INDEX_IN_W'(CAPACITY));
    cls.idx          = f_index[IDX_W-1:0];
    cls.new_action   = in_tdata[83:52];
  end

  assign in_tready = (fill_r < QCNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (fill_r != '0);
  assign q_cmd     = q_mem_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      unique case ({push, q_pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

/* design/wasc_back.sv */
// Back end: executes queued commands on the alarm table and scans for the next alarm.
// Depends on wasc_pkg and wasc_ram; drives the registered result.
module wasc_back import wasc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic q_pop,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MOVE,
    S_FETCH,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t             state_r;
  cmd_t               cmd_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_dec;
  logic [IDX_W-1:0]   sel_idx_r;
  logic               sel_vld_r;

  status_t            status_r;
  logic               fire_r;
  logic [TIME_W-1:0]  rtime_r;
  logic [MASK_W-1:0]  rmask_r;
  logic [ACT_W-1:0]   ract_r;
  logic [DELTA_W-1:0] delta_r;

  res_t               res_r;
  logic               out_vld_r;

  // scan pipeline
  logic [CNT_W-1:0]   scan_k_r;
  logic               v1_r, v2_r;
  logic [IDX_W-1:0]   k1_r, k2_r;
  logic               has2_r;
  logic [DAYS_W-1:0]  days2_r;
  logic [TIME_W-1:0]  t2_r;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  entry_t             ram_wdata, ram_rdata;

  logic               full, idx_ok, sel_ok;
  logic               s1_has;
  logic [DAYS_W-1:0]  s1_days;
  logic [SUM_W-1:0]   s2_sum;
  logic [DELTA_W-1:0] s2_delta;

  wasc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign count_dec = count_r - 1'b1;
  assign full      = (count_r >= CNT_W'(CAPACITY));
  assign idx_ok    = cmd_r.idx_in_range && (CNT_W'(cmd_r.idx) < count_r);
  assign sel_ok    = sel_vld_r && (CNT_W'(sel_idx_r) < count_r);
  assign q_pop     = (state_r == S_IDLE) && q_valid;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_r[IDX_W-1:0];
    ram_wdata = '{alarm_time: cmd_r.new_time, day_mask: cmd_r.new_mask,
                  action: cmd_r.new_action};
    ram_raddr = scan_k_r[IDX_W-1:0];
    unique case (state_r)
      S_EXEC: begin
        unique case (cmd_r.kind)
          CMD_INSERT:  ram_we    = !full;
          CMD_REMOVE:  ram_raddr = count_dec[IDX_W-1:0];
          CMD_TRIGGER: ram_raddr = sel_idx_r;
          CMD_INSPECT: ram_raddr = cmd_r.idx;
          default:     ram_we    = 1'b0;
        endcase
      end
      S_MOVE: begin
        // last entry fills the freed slot
        ram_we    = 1'b1;
        ram_waddr = cmd_r.idx;
        ram_wdata = ram_rdata;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // Stage 1: rotate the mask to start at today, then find the first firing day.
  always_comb begin
    logic [MASK_W-1:0]     rot;
    logic [2*MASK_W-1:0]   ext;
    logic [WDAY_W:0]       pos;
    logic                  off;
    rot = '0;
    pos = '0;
    off = (ram_rdata.alarm_time <= cmd_r.now_sec) && cmd_r.wday_ok &&
          ram_rdata.day_mask[cmd_r.wday];
    for (int j = 0; j < DAYS_PER_WEEK; j++) begin
      pos = (WDAY_W + 1)'(j) + {1'b0, cmd_r.wday};
      if (pos >= (WDAY_W + 1)'(DAYS_PER_WEEK)) begin
        pos = pos - (WDAY_W + 1)'(DAYS_PER_WEEK);
      end
      rot[j] = ram_rdata.day_mask[pos[WDAY_W-1:0]];
    end
    ext     = {rot, rot};
    s1_days = '0;
    for (int j = DAYS_PER_WEEK; j >= 0; j--) begin
      if (ext[j] && (j >= int'(off))) begin
        s1_days = DAYS_W'(j);
      end
    end
    s1_has = |ram_rdata.day_mask;
  end

  // Stage 2: seconds until firing, clamped at zero.
  assign s2_sum   = SUM_W'(t2_r) - SUM_W'(cmd_r.now_sec) + SUM_W'(day_seconds(days2_r));
  assign s2_delta = s2_sum[SUM_W-1] ? '0 : s2_sum[DELTA_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      sel_idx_r <= '0;
      sel_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      scan_k_r  <= '0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
    end else begin
      // load a new result, or drop the one just taken
      if ((state_r == S_FINISH) && (!out_vld_r || res_ready)) begin
        out_vld_r <= 1'b1;
      end else if (res_ready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r    <= q_cmd;
            status_r <= ST_OK;
            fire_r   <= 1'b0;
            rtime_r  <= '0;
            rmask_r  <= '0;
            ract_r   <= '0;
            delta_r  <= '0;
            state_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (cmd_r.kind)
            CMD_INSERT: begin
              if (full) begin
                status_r <= ST_FULL;
                state_r  <= S_FINISH;
              end else begin
                count_r   <= count_r + 1'b1;
                scan_k_r  <= '0;
                sel_vld_r <= 1'b0;
                sel_idx_r <= '0;
                state_r   <= S_SCAN;
              end
            end
            CMD_REMOVE: begin
              if (!idx_ok) begin
                status_r <= ST_BAD_INDEX;
                state_r  <= S_FINISH;
              end else begin
                count_r <= count_dec;
                state_r <= S_MOVE;
              end
            end
            CMD_RECOMPUTE: begin
              scan_k_r  <= '0;
              sel_vld_r <= 1'b0;
              sel_idx_r <= '0;
              state_r   <= S_SCAN;
            end
            CMD_TRIGGER: begin
              if (!sel_ok) begin
                status_r <= ST_NO_SEL;
                state_r  <= S_FINISH;
              end else begin
                state_r <= S_FETCH;
              end
            end
            CMD_INSPECT: begin
              if (!idx_ok) begin
                status_r <= ST_BAD_INDEX;
                state_r  <= S_FINISH;
              end else begin
                state_r <= S_FETCH;
              end
            end
            default: state_r <= S_FINISH;
          endcase
        end
        S_MOVE: begin
          scan_k_r  <= '0;
          sel_vld_r <= 1'b0;
          sel_idx_r <= '0;
          state_r   <= S_SCAN;
        end
        S_FETCH: begin
          ract_r <= ram_rdata.action;
          if (cmd_r.kind == CMD_TRIGGER) begin
            fire_r    <= 1'b1;
            scan_k_r  <= '0;
            sel_vld_r <= 1'b0;
            sel_idx_r <= '0;
            state_r   <= S_SCAN;
          end else begin
            rtime_r <= ram_rdata.alarm_time;
            rmask_r <= ram_rdata.day_mask;
            state_r <= S_FINISH;
          end
        end
        S_SCAN: begin
          if (scan_k_r < count_r) begin
            v1_r     <= 1'b1;
            k1_r     <= scan_k_r[IDX_W-1:0];
            scan_k_r <= scan_k_r + 1'b1;
          end else begin
            v1_r <= 1'b0;
          end
          v2_r    <= v1_r;
          k2_r    <= k1_r;
          has2_r  <= s1_has;
          days2_r <= s1_days;
          t2_r    <= ram_rdata.alarm_time;
          // strict compare keeps the lowest index on a tie
          if (v2_r && has2_r && (!sel_vld_r || (s2_delta < delta_r))) begin
            sel_vld_r <= 1'b1;
            sel_idx_r <= k2_r;
            delta_r   <= s2_delta;
          end
          if ((scan_k_r == count_r) && !v1_r && !v2_r) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_vld_r || res_ready) begin
            res_r.status      <= status_r;
            res_r.next_found  <= sel_vld_r;
            res_r.next_index  <= sel_vld_r ? INDEX_OUT_W'(sel_idx_r) : '0;
            res_r.next_delta  <= delta_r;
            res_r.fire        <= fire_r;
            res_r.read_time   <= rtime_r;
            res_r.read_mask   <= rmask_r;
            res_r.read_action <= ract_r;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign res_valid = out_vld_r;
  assign res       = res_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_sel_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && sel_vld_r |-> (CNT_W'(sel_idx_r) < count_r))
    else $error("selected entry outside the table");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !ram_we)
    else $error("table written during a scan");

  a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.fire |-> (res_r.status == ST_OK))
    else $error("fire reported with failing status");

  a_scan_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && $past(state_r) != S_SCAN |-> !v1_r && !v2_r)
    else $error("scan pipeline not empty at scan start");
`endif

endmodule

/* design/weekly_alarm_scheduler_core.sv */
// Top level of the weekly alarm scheduler: stream ports, front end and back end.
// Depends on wasc_pkg, wasc_front and wasc_back (which holds the wasc_ram table).
//
// Usage: each input item carries a command (insert, remove, recompute, trigger,
// inspect) with the current second of day and weekday; every item yields exactly
// one result item carrying status, the next selected alarm and any read data.
// The front end accepts items into a two-entry command queue, so in_tready
// stays high while the back end is busy, until the queue fills.
// The back end runs one command at a time, so one item finishes before the next
// starts. An inspect reads the table; a scanning command (successful insert,
// remove, trigger, or recompute) scans the table through a two-stage delta
// pipeline, reading one alarm-table entry per cycle from the single RAM read
// port. A remove first moves the last entry into the freed slot, and a trigger
// first fetches the action.
// Results sit in an output register; while out_tready is low the back end
// holds its next result and the queue absorbs up to two further items.
// Reset (rst_n low, synchronous) empties the table and the queue and clears
// the selection; table contents stay undefined until written.
module weekly_alarm_scheduler_core import wasc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // now_seconds, now_weekday, new_alarm_time, new_day_mask, entry_index, new_action
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  logic [OPC_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // next_found, next_index, next_delta, fire, read_time, read_mask, read_action
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status
  output logic [STATUS_W-1:0]   out_tuser
);

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;
  res_t res;

  wasc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  wasc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tuser = res.status;
  assign out_tdata = {6'd0, res.read_action, res.read_mask, res.read_time, res.fire,
                      res.next_delta, res.next_index, res.next_found};

endmodule
